/* src/bnc_pkg.sv */
// ----------------------------------------------------------------------------
// bnc_pkg: shared types and constants
// Bug1 navigation controller types, fixed-point constants and CORDIC table.
// ----------------------------------------------------------------------------
package bnc_pkg;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [15:0] heading;
    logic        [11:0] prox_front_a;
    logic        [11:0] prox_front_b;
    logic        [11:0] prox_side_align;
    logic        [11:0] prox_side_follow;
    logic               target_seen;
  } nav_in_t;

  typedef struct packed {
    logic signed [15:0] spd_left;
    logic signed [15:0] spd_right;
    logic        [1:0]  led_color;
    logic        [2:0]  mode;
  } nav_out_t;

  typedef enum logic [2:0] {
    MODE_GOAL    = 3'd0,
    MODE_ALIGN   = 3'd1,
    MODE_FOLLOW  = 3'd2,
    MODE_CLOSEST = 3'd3,
    MODE_STOP    = 3'd4
  } nav_mode_t;

  localparam logic [1:0] LED_BLUE   = 2'd0;
  localparam logic [1:0] LED_YELLOW = 2'd1;
  localparam logic [1:0] LED_GREEN  = 2'd2;
  localparam logic [1:0] LED_HOLD   = 2'd3;

  localparam logic [2:0] REG_TX    = 3'd0;
  localparam logic [2:0] REG_TY    = 3'd1;
  localparam logic [2:0] REG_GP    = 3'd2;
  localparam logic [2:0] REG_GI    = 3'd3;
  localparam logic [2:0] REG_GD    = 3'd4;
  localparam logic [2:0] REG_FRONT = 3'd5;

  localparam int DESIRED_PROX   = 205;
  localparam int SPEED_SLOW     = 205;
  localparam int SPEED_FAST     = 410;
  localparam logic [31:0] LEAVE_SQ_MIN  = 32'd167773;
  localparam logic [31:0] RETURN_SQ_MAX = 32'd167772;
  localparam logic [31:0] ARRIVE_SQ_MAX = 32'd107374;
  localparam int ALIGN_PROX_MAX = 409;
  localparam int HEADING_TOL    = 1043;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0: t = 32'd536870912;  5'd1: t = 32'd316933406;
      5'd2: t = 32'd167458907;  5'd3: t = 32'd85004756;
      5'd4: t = 32'd42667331;   5'd5: t = 32'd21354465;
      5'd6: t = 32'd10679838;   5'd7: t = 32'd5340245;
      5'd8: t = 32'd2670163;    5'd9: t = 32'd1335087;
      5'd10: t = 32'd667544;    5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;    5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;     5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;     5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;       5'd21: t = 32'd326;
      5'd22: t = 32'd163;       5'd23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

/* src/bnc_if.sv */
// ----------------------------------------------------------------------------
// bnc_in_if / bnc_out_if: valid-ready channels
// Carry one input beat or one result beat.
// ----------------------------------------------------------------------------
interface bnc_in_if;
  logic valid;
  logic ready;
  bnc_pkg::nav_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bnc_out_if;
  logic valid;
  logic ready;
  bnc_pkg::nav_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/bug1_navigation_controller.sv */
// ----------------------------------------------------------------------------
// bug1_navigation_controller: Bug1 obstacle avoidance with PID wall following
// Sequencing: after accept, six distance products (S_DIST), then a mode
//   decision, then the CORDIC bearing loop when the goal heading is aimed,
//   three gain products and a wheel update when the PID runs, or neither.
//   in_ready is low from accept until the result beat is taken, so a new
//   beat is not taken before the last result is out.
// Reset: synchronous active-low rst_n; mode go-to-goal, registers at defaults.
// ----------------------------------------------------------------------------
module bug1_navigation_controller #(
  parameter int LEAVE_TICKS  = 150,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bnc_in_if.sink      in_ch,
  bnc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bnc_pkg::*;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIST  = 7'b0000010,  // squared distances through the shared multiplier
    S_DEC   = 7'b0000100,  // mode decision
    S_CORD  = 7'b0001000,  // waiting on bearing
    S_PID   = 7'b0010000,  // three gain products
    S_WHEEL = 7'b0100000,
    S_OUT   = 7'b1000000
  } seq_t;

  seq_t state_r, state_nxt;

  // config registers
  logic signed [15:0] tx_r, ty_r, gp_r, gi_r, gd_r;
  logic [11:0] flim_r;

  // navigation state
  nav_mode_t mode_r;
  logic [7:0]  timer_r;
  logic [31:0] hit_r, close_r, cdist_r;
  logic        left_r;
  logic signed [23:0] integ_r;
  logic signed [12:0] perr_r;
  logic [31:0] wheel_r;

  // latched beat
  nav_in_t in_r;
  logic [1:0]  led_r;

  // shared multiplier and accumulator
  logic [3:0]  step_r;
  logic signed [24:0] ma, mb;
  logic signed [49:0] prod;
  logic signed [51:0] acc_r;
  logic [31:0] dg_r, dh_r, dc_r;
  logic signed [13:0] err_r;
  logic signed [23:0] inew_r;
  logic pid_sgn_r;  // 0 wall follow, 1 align sign

  // config port
  logic cfg_wr;
  logic [2:0] cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      REG_TX:    cfg_prdata = 32'(signed'(tx_r));
      REG_TY:    cfg_prdata = 32'(signed'(ty_r));
      REG_GP:    cfg_prdata = 32'(signed'(gp_r));
      REG_GI:    cfg_prdata = 32'(signed'(gi_r));
      REG_GD:    cfg_prdata = 32'(signed'(gd_r));
      REG_FRONT: cfg_prdata = {20'd0, flim_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // cordic
  logic cord_start, cord_done;
  logic [15:0] bearing;
  logic signed [16:0] gdx, gdy;
  assign gdx = 17'(tx_r) - 17'(in_r.pos_x);
  assign gdy = 17'(ty_r) - 17'(in_r.pos_y);

  bnc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cord_start),
    .dx(gdx), .dy(gdy), .done(cord_done), .bearing(bearing)
  );

  // difference operand selection for distance steps
  logic signed [15:0] rx, ry;
  logic signed [16:0] dd;
  always_comb begin
    unique case (step_r[2:1])
      2'd0: begin rx = tx_r; ry = ty_r; end
      2'd1: begin rx = hit_r[15:0]; ry = hit_r[31:16]; end
      default: begin rx = close_r[15:0]; ry = close_r[31:16]; end
    endcase
    dd = step_r[0] ? (17'(in_r.pos_y) - 17'(ry)) : (17'(in_r.pos_x) - 17'(rx));
  end

  always_comb begin
    ma = 25'(dd);
    mb = 25'(dd);
    if (state_r == S_PID) begin
      unique case (step_r[1:0])
        2'd0: begin ma = 25'(gp_r); mb = 25'(err_r); end
        2'd1: begin ma = 25'(gi_r); mb = 25'(inew_r); end
        default: begin ma = 25'(gd_r); mb = 25'(err_r) - 25'(perr_r); end
      endcase
    end
  end
  assign prod = ma * mb;

  function automatic logic [31:0] sat32u(input logic signed [51:0] v);
    return (v > 52'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [51:0] v);
    if (v > 52'sd32767) return 16'h7FFF;
    if (v < -52'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  // pid helpers
  logic signed [13:0] err_sel;
  logic signed [24:0] isum;
  logic signed [51:0] ctl_full;
  assign err_sel = 14'(DESIRED_PROX) -
    14'({1'b0, (mode_r == MODE_ALIGN) ? in_r.prox_side_align : in_r.prox_side_follow});
  assign isum = 25'(integ_r) + 25'(err_sel);
  assign ctl_full = acc_r >>> 8;

  logic [16:0] hdiff;
  logic signed [16:0] hd;
  assign hd = 17'({1'b0, in_r.heading}) - 17'({1'b0, bearing});
  assign hdiff = hd[16] ? 17'(-hd) : 17'(hd);

  logic front_hit;
  assign front_hit = (in_r.prox_front_a < flim_r) || (in_r.prox_front_b < flim_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data.spd_left = wheel_r[15:0];
  assign out_ch.data.spd_right = wheel_r[31:16];
  assign out_ch.data.led_color = led_r;
  assign out_ch.data.mode = mode_r;

  assign cord_start = (state_r == S_DEC) && (mode_r == MODE_GOAL) &&
                      !in_r.target_seen && !(front_hit && timer_r == 8'd0);

  logic signed [51:0] lw, rw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tx_r <= '0; ty_r <= '0; gp_r <= 16'sd256; gi_r <= '0; gd_r <= '0;
      flim_r <= 12'd205;
      mode_r <= MODE_GOAL;
      timer_r <= '0;
      hit_r <= '0; close_r <= '0; cdist_r <= '1;
      left_r <= 1'b0;
      integ_r <= '0; perr_r <= '0; wheel_r <= '0;
      step_r <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_TX:    tx_r <= cfg_pwdata[15:0];
          REG_TY:    ty_r <= cfg_pwdata[15:0];
          REG_GP:    gp_r <= cfg_pwdata[15:0];
          REG_GI:    gi_r <= cfg_pwdata[15:0];
          REG_GD:    gd_r <= cfg_pwdata[15:0];
          REG_FRONT: flim_r <= cfg_pwdata[11:0];
          default: ;
        endcase
      end
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            in_r <= in_ch.data;
            if (timer_r != 0) timer_r <= timer_r - 8'd1;
            step_r <= '0;
            acc_r <= '0;
          end
        end
        S_DIST: begin
          // even step: dx^2, odd step: add dy^2 and store
          if (!step_r[0]) acc_r <= 52'(prod);
          else begin
            unique case (step_r[2:1])
              2'd0: dg_r <= sat32u(acc_r + 52'(prod));
              2'd1: dh_r <= sat32u(acc_r + 52'(prod));
              default: dc_r <= sat32u(acc_r + 52'(prod));
            endcase
          end
          step_r <= step_r + 4'd1;
        end
        S_DEC: begin
          step_r <= '0;
          acc_r <= '0;
          err_r <= err_sel;
          inew_r <= (isum > 25'sd8388607) ? 24'sh7FFFFF :
                    (isum < -25'sd8388608) ? 24'sh800000 : isum[23:0];
          unique case (mode_r)
            MODE_GOAL: begin
              led_r <= LED_BLUE;
              if (in_r.target_seen) mode_r <= MODE_STOP;
              else if (front_hit && timer_r == 8'd0) begin
                left_r <= 1'b0;
                hit_r <= {in_r.pos_y, in_r.pos_x};
                close_r <= {in_r.pos_y, in_r.pos_x};
                cdist_r <= dg_r;
                mode_r <= MODE_ALIGN;
              end
            end
            MODE_ALIGN: begin
              led_r <= LED_YELLOW;
              pid_sgn_r <= 1'b1;
              if (in_r.prox_side_align >= 12'd1 &&
                  in_r.prox_side_align <= 12'(ALIGN_PROX_MAX)) begin
                mode_r <= MODE_FOLLOW;
                integ_r <= '0;
              end
            end
            MODE_FOLLOW: begin
              led_r <= LED_YELLOW;
              pid_sgn_r <= 1'b0;
              if (dg_r < cdist_r) begin
                cdist_r <= dg_r;
                close_r <= {in_r.pos_y, in_r.pos_x};
              end
              if (!left_r) begin
                if (dh_r >= LEAVE_SQ_MIN) left_r <= 1'b1;
              end else if (dh_r <= RETURN_SQ_MAX) mode_r <= MODE_CLOSEST;
            end
            MODE_CLOSEST: begin
              led_r <= LED_GREEN;
              pid_sgn_r <= 1'b0;
              if (dc_r <= ARRIVE_SQ_MAX) begin
                timer_r <= 8'(LEAVE_TICKS);
                mode_r <= MODE_GOAL;
              end
            end
            default: begin
              led_r <= LED_HOLD;
              mode_r <= MODE_STOP;
              wheel_r <= '0;
            end
          endcase
        end
        S_CORD: begin
          if (cord_done) begin
            if (hdiff > 17'(HEADING_TOL))
              wheel_r <= {16'(-SPEED_SLOW), 16'(SPEED_SLOW)};
            else
              wheel_r <= {16'(SPEED_FAST), 16'(SPEED_FAST)};
          end
        end
        S_PID: begin
          acc_r <= acc_r + 52'(prod);
          step_r <= step_r + 4'd1;
          if (step_r == 4'd2) begin
            integ_r <= inew_r;
            perr_r <= err_r[12:0];
          end
        end
        S_WHEEL: begin
          wheel_r <= {sat16(rw), sat16(lw)};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pid_sgn_r) begin
      lw = 52'(-SPEED_SLOW) + ctl_full;
      rw = 52'(SPEED_SLOW) - ctl_full;
    end else begin
      lw = 52'(SPEED_FAST) + ctl_full;
      rw = 52'(SPEED_FAST) - ctl_full;
    end
  end

  // pid is needed when the decided mode still commands wheels via the loop
  logic pid_go;
  always_comb begin
    pid_go = 1'b0;
    unique case (mode_r)
      MODE_ALIGN: pid_go = !(in_r.prox_side_align >= 12'd1 &&
                             in_r.prox_side_align <= 12'(ALIGN_PROX_MAX));
      MODE_FOLLOW: pid_go = !(left_r && dh_r <= RETURN_SQ_MAX);
      MODE_CLOSEST: pid_go = !(dc_r <= ARRIVE_SQ_MAX);
      default: pid_go = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_DIST;
      S_DIST:  if (step_r == 4'd5) state_nxt = S_DEC;
      S_DEC: begin
        if (cord_start) state_nxt = S_CORD;
        else if (pid_go) state_nxt = S_PID;
        else state_nxt = S_OUT;
      end
      S_CORD:  if (cord_done) state_nxt = S_OUT;
      S_PID:   if (step_r == 4'd2) state_nxt = S_WHEEL;
      S_WHEEL: state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");
  out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_ch.ready) |=> state_r == S_OUT)
    else $error("result dropped");
  ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready during result");
  stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_STOP) |=> (mode_r == MODE_STOP)) else $error("left stop mode");

endmodule

/* src/bnc_cordic.sv */
// ----------------------------------------------------------------------------
// bnc_cordic: iterative vectoring CORDIC
// One micro-rotation per cycle, returns a 16-bit bearing of (dx, dy).
// ----------------------------------------------------------------------------
module bnc_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dy,
  output logic               done,
  output logic        [15:0] bearing
);
  import bnc_pkg::*;

  localparam int CW = 20;

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic signed [CW-1:0] xs, ys;
  logic [31:0] acc_rnd;

  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      step_nxt = '0;
      if (dx == 0 && dy == 0) begin
        acc_nxt = '0;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        if (dx < 0) begin
          x_nxt = -CW'(dx);
          y_nxt = -CW'(dy);
          acc_nxt = 32'h8000_0000;
        end else begin
          x_nxt = CW'(dx);
          y_nxt = CW'(dy);
          acc_nxt = '0;
        end
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        acc_nxt = acc_r + atan_turn(step_r);
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        acc_nxt = acc_r - atan_turn(step_r);
      end
      step_nxt = step_r + 5'd1;
      if (32'(step_r) == STEPS - 1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign acc_rnd = acc_r + 32'h8000;
  assign bearing = acc_rnd[31:16];
  assign done = done_r;

  done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("cordic done while busy");
  step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> 32'(step_r) < STEPS) else $error("cordic step overrun");
  start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("cordic restarted while busy");

endmodule
